// ===== design/length_prefixed_frame_deframer_macros.svh =====
// Assertion macros shared by the deframer modules.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH
`ifndef SYNTHESIS
`define LPFD_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define LPFD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LPFD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPFD_ASSERT(label, cond, msg)
`define LPFD_ASSERT_IMP(label, ante, cons, msg)
`define LPFD_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== design/lpfd_pkg.sv =====
// Shared types and constants for the length-prefixed frame deframer.
package lpfd_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam logic [31:0] HEADER_BYTES = 32'd8;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Byte classes handed from the front end to the back end.
  typedef enum logic [2:0] {
    CMD_LEN,
    CMD_LEN_ERR,
    CMD_TYPE,
    CMD_ID,
    CMD_HDR,
    CMD_PAY,
    CMD_PAY_LAST
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
  } q_entry_t;

endpackage

// ===== design/lpfd_front.sv =====
// Front end: accepts stream bytes, tracks frame position, tags each byte.
module lpfd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               push_valid,
  input  logic               push_ready,
  output lpfd_pkg::q_entry_t push_entry
);

  typedef enum logic [1:0] {
    PH_LEN,
    PH_TYPE,
    PH_ID,
    PH_PAY
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] plen;
  lpfd_pkg::cmd_t cmd;
  logic        take;

  assign take       = in_valid && push_ready;
  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign push_entry = '{cmd: cmd, data: in_rx_byte};
  assign plen       = len_r - lpfd_pkg::HEADER_BYTES;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r + 2'd1;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    cmd       = lpfd_pkg::CMD_LEN;
    case (phase_r)
      PH_LEN: begin
        len_nxt = {len_r[23:0], in_rx_byte};
        if (cnt_r == 2'd3) begin
          // length below eight: flag it and read a fresh length
          if (len_nxt[31:3] == 29'd0) begin
            cmd = lpfd_pkg::CMD_LEN_ERR;
          end else begin
            phase_nxt = PH_TYPE;
          end
        end
      end
      PH_TYPE: begin
        cmd = lpfd_pkg::CMD_TYPE;
        if (cnt_r == 2'd3) begin
          phase_nxt = PH_ID;
        end
      end
      PH_ID: begin
        cmd = lpfd_pkg::CMD_ID;
        if (cnt_r == 2'd3) begin
          cmd       = lpfd_pkg::CMD_HDR;
          rem_nxt   = plen;
          phase_nxt = (plen == 32'd0) ? PH_LEN : PH_PAY;
        end
      end
      PH_PAY: begin
        cnt_nxt = 2'd0;
        rem_nxt = rem_r - 32'd1;
        if (rem_r == 32'd1) begin
          cmd       = lpfd_pkg::CMD_PAY_LAST;
          phase_nxt = PH_LEN;
        end else begin
          cmd = lpfd_pkg::CMD_PAY;
        end
      end
      default: begin
        phase_nxt = PH_LEN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      cnt_r   <= 2'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
    if (take) begin
      len_r <= len_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

// ===== design/lpfd_queue.sv =====
// Small FIFO of tagged bytes between front end and back end.
`include "length_prefixed_frame_deframer_macros.svh"
module lpfd_queue #(
  parameter int unsigned DEPTH = lpfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  lpfd_pkg::q_entry_t push_entry,
  output logic               pop_valid,
  input  logic               pop_ready,
  output lpfd_pkg::q_entry_t pop_entry
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lpfd_pkg::q_entry_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic push, pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  `LPFD_ASSERT(a_count_range, count_r <= CNT_FULL, "queue count beyond depth")
  `LPFD_ASSERT_NXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1,
                   "queue count did not grow on push")
  `LPFD_ASSERT_IMP(a_ptr_gap, count_r == '0 || count_r == CNT_FULL, wr_ptr_r == rd_ptr_r,
                   "pointers disagree with an empty or full queue")

endmodule

// ===== design/lpfd_back.sv =====
// Back end: assembles header words from tagged bytes and drives the results.
`include "length_prefixed_frame_deframer_macros.svh"
module lpfd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  lpfd_pkg::q_entry_t pop_entry,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_result_kind,
  output logic [7:0]         out_payload_byte,
  output logic [31:0]        out_message_type,
  output logic [31:0]        out_message_id,
  output logic [31:0]        out_payload_length,
  output logic               out_last_of_message
);

  logic [31:0] len_r, type_r, id_r;
  logic [31:0] len_nxt, type_nxt, id_nxt, plen;
  logic        out_valid_r;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [31:0] otype_r, otype_nxt, oid_r, oid_nxt, oplen_r, oplen_nxt;
  logic        last_r, last_nxt;
  logic        produces, pop, load;

  assign plen = len_r - lpfd_pkg::HEADER_BYTES;

  always_comb begin
    len_nxt   = len_r;
    type_nxt  = type_r;
    id_nxt    = id_r;
    produces  = 1'b1;
    kind_nxt  = lpfd_pkg::KIND_PAYLOAD;
    byte_nxt  = 8'd0;
    otype_nxt = type_r;
    oid_nxt   = id_r;
    oplen_nxt = plen;
    last_nxt  = 1'b0;
    case (pop_entry.cmd)
      lpfd_pkg::CMD_LEN: begin
        produces = 1'b0;
        len_nxt  = {len_r[23:0], pop_entry.data};
      end
      lpfd_pkg::CMD_LEN_ERR: begin
        len_nxt   = {len_r[23:0], pop_entry.data};
        kind_nxt  = lpfd_pkg::KIND_ERROR;
        otype_nxt = 32'd0;
        oid_nxt   = 32'd0;
        oplen_nxt = 32'd0;
        last_nxt  = 1'b1;
      end
      lpfd_pkg::CMD_TYPE: begin
        produces = 1'b0;
        type_nxt = {type_r[23:0], pop_entry.data};
      end
      lpfd_pkg::CMD_ID: begin
        produces = 1'b0;
        id_nxt   = {id_r[23:0], pop_entry.data};
      end
      lpfd_pkg::CMD_HDR: begin
        id_nxt   = {id_r[23:0], pop_entry.data};
        kind_nxt = lpfd_pkg::KIND_HEADER;
        oid_nxt  = id_nxt;
        last_nxt = (plen == 32'd0);
      end
      lpfd_pkg::CMD_PAY: begin
        byte_nxt = pop_entry.data;
      end
      lpfd_pkg::CMD_PAY_LAST: begin
        byte_nxt = pop_entry.data;
        last_nxt = 1'b1;
      end
      default: begin
        produces = 1'b0;
      end
    endcase
  end

  // Non-result bytes drain even while a result is held.
  assign pop_ready = !produces || !out_valid_r || out_ready;
  assign pop       = pop_valid && pop_ready;
  assign load      = pop && produces;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (pop) begin
      len_r  <= len_nxt;
      type_r <= type_nxt;
      id_r   <= id_nxt;
    end
    if (load) begin
      kind_r  <= kind_nxt;
      byte_r  <= byte_nxt;
      otype_r <= otype_nxt;
      oid_r   <= oid_nxt;
      oplen_r <= oplen_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = kind_r;
  assign out_payload_byte    = byte_r;
  assign out_message_type    = otype_r;
  assign out_message_id      = oid_r;
  assign out_payload_length  = oplen_r;
  assign out_last_of_message = last_r;

  `LPFD_ASSERT_IMP(a_err_fields, out_valid_r && kind_r == lpfd_pkg::KIND_ERROR,
                   otype_r == 32'd0 && oid_r == 32'd0 && oplen_r == 32'd0 && last_r,
                   "error result carries frame fields")
  `LPFD_ASSERT_IMP(a_hdr_last, out_valid_r && kind_r == lpfd_pkg::KIND_HEADER,
                   last_r == (oplen_r == 32'd0), "header last flag wrong")
  `LPFD_ASSERT_IMP(a_byte_zero, out_valid_r && kind_r != lpfd_pkg::KIND_PAYLOAD,
                   byte_r == 8'd0, "payload byte set outside payload result")

endmodule

// ===== design/length_prefixed_frame_deframer.sv =====
// Top level of the length-prefixed frame deframer.
//
// Input channel (in_valid/in_ready/in_rx_byte) takes one stream byte per
// transfer. A frame is a 4-byte big-endian length, a 32-bit type, a 32-bit
// id, then payload; the length counts type, id and payload.
// Output channel (out_valid/out_ready/out_*) gives one header result after
// the last id byte, one result per payload byte (last byte flagged), and
// one framing-error result for a length below eight, after which the next
// four bytes are read as a new length. Other bytes give no result.
// Throughput: one byte per cycle, sustained while out_ready stays high.
// Each byte is registered in the queue, then the back end pops it and
// registers its result in the output register.
// When the receiver stalls, the held result waits in the output register,
// bytes that give no result keep draining, and the queue of QUEUE_DEPTH
// entries fills; in_ready then drops until a result leaves.
// Synchronous reset returns to the length phase with the queue and output
// empty.
module length_prefixed_frame_deframer #(
  parameter int unsigned QUEUE_DEPTH = lpfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic [31:0] out_message_type,
  output logic [31:0] out_message_id,
  output logic [31:0] out_payload_length,
  output logic        out_last_of_message
);

  logic               push_valid, push_ready, pop_valid, pop_ready;
  lpfd_pkg::q_entry_t push_entry, pop_entry;

  lpfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  lpfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  lpfd_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .pop_valid           (pop_valid),
    .pop_ready           (pop_ready),
    .pop_entry           (pop_entry),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_payload_byte    (out_payload_byte),
    .out_message_type    (out_message_type),
    .out_message_id      (out_message_id),
    .out_payload_length  (out_payload_length),
    .out_last_of_message (out_last_of_message)
  );

endmodule
